// ===== hw/rtl/mas_pkg.sv =====
package mas_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int VAL_W   = 32;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = PROD_W + IDX_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // action codes
  localparam logic [1:0] ACT_WR_A    = 2'd0;
  localparam logic [1:0] ACT_WR_B    = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;
  // unused code, ignored by the block
  localparam logic [1:0] ACT_NOP     = 2'd3;

  // mode codes
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_SUB   = 2'd1;
  localparam logic [1:0] MODE_MUL   = 2'd2;
  localparam logic [1:0] MODE_TRANS = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 3'd4;

  // operation kinds
  localparam logic [2:0] KIND_ELEM   = 3'd0;
  localparam logic [2:0] KIND_A_B00  = 3'd1;
  localparam logic [2:0] KIND_A00_B  = 3'd2;
  localparam logic [2:0] KIND_MATMUL = 3'd3;
  localparam logic [2:0] KIND_TRANS  = 3'd4;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
    logic                    error;
  } out_item_t;

  // datapath control
  typedef struct packed {
    logic op_en;   // form product or sum from x and y
    logic mul;
    logic sub;
    logic pass;    // forward x unchanged
    logic acc_en;  // fold product into accumulator
    logic first;   // first term of a dot product
  } dp_ctrl_t;

endpackage

// ===== hw/rtl/mas_ram.sv =====
module mas_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mas_dp.sv =====
module mas_dp import mas_pkg::*; (
  input  logic                    clk,
  input  dp_ctrl_t                ctrl,
  input  logic signed [VAL_W-1:0] x,
  input  logic signed [VAL_W-1:0] y,
  output logic signed [VAL_W-1:0] result
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_mul;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_mul;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [ACC_W-1:0]  src;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(signed'(64'sh7FFFFFFF));
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(signed'(64'sh80000000));
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (VAL_W / 2 - 1);

  // product, sum or pass-through stage
  always_ff @(posedge clk) begin
    if (ctrl.op_en) begin
      prod_mul <= ctrl.mul;
      if (ctrl.mul) begin
        prod <= PROD_W'(x) * PROD_W'(y);
      end else if (ctrl.pass) begin
        prod <= PROD_W'(x);
      end else if (ctrl.sub) begin
        prod <= PROD_W'(x) - PROD_W'(y);
      end else begin
        prod <= PROD_W'(x) + PROD_W'(y);
      end
    end
  end

  // full width accumulator
  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      acc_mul <= prod_mul;
      if (ctrl.first || !prod_mul) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // round half up to q16.16 for products, then saturate
  always_comb begin
    rnd     = acc + HALF;
    shifted = rnd >>> (VAL_W / 2);
    src     = acc_mul ? shifted : acc;
    if (src > SAT_MAX) begin
      result = SAT_MAX[VAL_W-1:0];
    end else if (src < SAT_MIN) begin
      result = SAT_MIN[VAL_W-1:0];
    end else begin
      result = src[VAL_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/matrix_add_sub_mul_transpose.sv =====
// Small matrix unit, signed Q16.16 elements, up to 8x8. Element writes
// (action 0 for A, 1 for B) are taken one per cycle whenever the block is
// idle. A compute item walks the stored matrices and emits the result
// row-major with last set on the final element; a size mismatch gives one
// item with error set. After the compute item is taken there is a setup
// step. Each result element then passes through the memory read,
// multiply/add and accumulate steps once per term (one term for add,
// subtract, transpose and scalar forms, cols_a terms for a full multiply)
// and then through the emit step; a stalled output holds the emit step.
// Input stall stays high for the whole compute run. No entry is cleared by
// reset: every element that a compute reads must have been written first.
module matrix_add_sub_mul_transpose import mas_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]            state;
  logic [1:0]            mode;
  logic [DIM_W-1:0]      rows_a, cols_a, rows_b, cols_b;
  logic [DIM_W-1:0]      ra, ca, rb, cb;
  logic                  a1, b1, same;
  logic [2:0]            kind, kind_next;
  logic                  err, err_next;
  logic [DIM_W-1:0]      orow, ocol, kn;
  logic [DIM_W-1:0]      orow_next, ocol_next, kn_next;
  logic [IDX_W-1:0]      i, j, k;
  logic signed [VAL_W-1:0] a00, b00;
  logic [ADDR_W-1:0]     addr_a, addr_b;
  logic [VAL_W-1:0]      rdata_a, rdata_b;
  logic signed [VAL_W-1:0] x, y;
  logic                  in_acc, we_a, we_b;
  logic                  last_el, slot_free;
  dp_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] result;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return d;
    end
  endfunction

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign we_a      = in_acc && (in_item.action == ACT_WR_A);
  assign we_b      = in_acc && (in_item.action == ACT_WR_B);
  assign slot_free = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_ADD;
      rows_a <= DIM_W'(1);
      cols_a <= DIM_W'(1);
      rows_b <= DIM_W'(1);
      cols_b <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode   <= cfg_data[1:0];
        REG_ROWS_A: rows_a <= cfg_data;
        REG_COLS_A: cols_a <= cfg_data;
        REG_ROWS_B: rows_b <= cfg_data;
        REG_COLS_B: cols_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // scalar copies of the first element of each matrix
  always_ff @(posedge clk) begin
    if (we_a && in_item.row == '0 && in_item.col == '0) begin
      a00 <= in_item.value;
    end
    if (we_b && in_item.row == '0 && in_item.col == '0) begin
      b00 <= in_item.value;
    end
  end

  mas_ram #(.DEPTH(CELLS), .WIDTH(VAL_W)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr ({in_item.row, in_item.col}),
    .wdata (in_item.value),
    .raddr (addr_a),
    .rdata (rdata_a)
  );

  mas_ram #(.DEPTH(CELLS), .WIDTH(VAL_W)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr ({in_item.row, in_item.col}),
    .wdata (in_item.value),
    .raddr (addr_b),
    .rdata (rdata_b)
  );

  // size checks
  always_comb begin
    ra   = clamp_dim(rows_a);
    ca   = clamp_dim(cols_a);
    rb   = clamp_dim(rows_b);
    cb   = clamp_dim(cols_b);
    a1   = (ra == DIM_W'(1)) && (ca == DIM_W'(1));
    b1   = (rb == DIM_W'(1)) && (cb == DIM_W'(1));
    same = (ra == rb) && (ca == cb);
  end

  // operation and result size picked at setup
  always_comb begin
    kind_next = KIND_ELEM;
    orow_next = DIM_W'(1);
    ocol_next = DIM_W'(1);
    kn_next   = DIM_W'(1);
    err_next  = 1'b0;
    if (mode == MODE_TRANS) begin
      kind_next = KIND_TRANS;
      orow_next = ca;
      ocol_next = ra;
    end else if (mode == MODE_ADD && b1) begin
      kind_next = KIND_A_B00;
      orow_next = ra;
      ocol_next = ca;
    end else if (mode == MODE_ADD && a1) begin
      kind_next = KIND_A00_B;
      orow_next = rb;
      ocol_next = cb;
    end else if (mode == MODE_SUB && b1) begin
      kind_next = KIND_A_B00;
      orow_next = ra;
      ocol_next = ca;
    end else if ((mode == MODE_ADD || mode == MODE_SUB) && same) begin
      kind_next = KIND_ELEM;
      orow_next = ra;
      ocol_next = ca;
    end else if (mode == MODE_MUL && a1) begin
      kind_next = KIND_A00_B;
      orow_next = rb;
      ocol_next = cb;
    end else if (mode == MODE_MUL && b1) begin
      kind_next = KIND_A_B00;
      orow_next = ra;
      ocol_next = ca;
    end else if (mode == MODE_MUL && ca == rb) begin
      kind_next = KIND_MATMUL;
      orow_next = ra;
      ocol_next = cb;
      kn_next   = ca;
    end else begin
      err_next  = 1'b1;
    end
  end

  // read addresses
  always_comb begin
    unique case (kind)
      KIND_MATMUL: begin
        addr_a = {i, k};
        addr_b = {k, j};
      end
      KIND_TRANS: begin
        addr_a = {j, i};
        addr_b = {i, j};
      end
      default: begin
        addr_a = {i, j};
        addr_b = {i, j};
      end
    endcase
  end

  // operand selection
  always_comb begin
    unique case (kind)
      KIND_A_B00: begin
        x = rdata_a;
        y = b00;
      end
      KIND_A00_B: begin
        x = rdata_b;
        y = a00;
      end
      default: begin
        x = rdata_a;
        y = rdata_b;
      end
    endcase
  end

  always_comb begin
    ctrl        = '0;
    ctrl.op_en  = (state == ST_MUL);
    ctrl.mul    = (mode == MODE_MUL);
    ctrl.sub    = (mode == MODE_SUB);
    ctrl.pass   = (kind == KIND_TRANS);
    ctrl.acc_en = (state == ST_ACC);
    ctrl.first  = (k == '0);
  end

  mas_dp u_dp (
    .clk    (clk),
    .ctrl   (ctrl),
    .x      (x),
    .y      (y),
    .result (result)
  );

  assign last_el = err || ((DIM_W'(i) == orow - DIM_W'(1)) &&
                           (DIM_W'(j) == ocol - DIM_W'(1)));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the item once taken, unless the emit step refills the slot
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && in_item.action == ACT_COMPUTE) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          i    <= '0;
          j    <= '0;
          k    <= '0;
          kind <= kind_next;
          orow <= orow_next;
          ocol <= ocol_next;
          kn   <= kn_next;
          err  <= err_next;
          if (err_next) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (DIM_W'(k) == kn - DIM_W'(1)) begin
            state <= ST_EMIT;
          end else begin
            k     <= k + IDX_W'(1);
            state <= ST_RD;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid          <= 1'b1;
            out_item.out_row   <= err ? '0 : i;
            out_item.out_col   <= err ? '0 : j;
            out_item.out_value <= err ? '0 : result;
            out_item.last      <= last_el;
            out_item.error     <= err;
            k                  <= '0;
            if (last_el) begin
              state <= ST_IDLE;
            end else begin
              if (DIM_W'(j) == ocol - DIM_W'(1)) begin
                j <= '0;
                i <= i + IDX_W'(1);
              end else begin
                j <= j + IDX_W'(1);
              end
              state <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.error |-> out_item.last)
    else $error("error item without last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.error |-> out_item.out_value == '0)
    else $error("error item carries a value");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD |-> DIM_W'(k) < kn)
    else $error("term index past bound");

  a_emit_wait: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && !slot_free |=> state == ST_EMIT)
    else $error("result dropped while output full");
`endif

endmodule

// ===== tb/tb.sv =====
module tb import mas_pkg::*; ();

  localparam int SETTLE    = 24;
  localparam int ITEM_GOAL = 470;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  matrix_add_sub_mul_transpose u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow copy of the block: element stores and register file
  logic signed [VAL_W-1:0] mat_a [CELLS];
  logic signed [VAL_W-1:0] mat_b [CELLS];
  logic [CFG_DATA_W-1:0]   regs [5];

  out_item_t result_q [$];
  int  fails = 0;
  int  n_items = 0, n_results = 0, n_computes = 0, n_size_errs = 0;
  bit  quiet = 1'b0;
  int  out_hold = 0;

  function automatic logic [ADDR_W-1:0] cell_idx(int r, int c);
    return ADDR_W'(r * MAX_DIM + c);
  endfunction

  function automatic int eff_dim(logic [CFG_DATA_W-1:0] d);
    int dv;
    dv = int'(d);
    if (dv == 0) return 1;
    if (dv > MAX_DIM) return MAX_DIM;
    return dv;
  endfunction

  function automatic logic signed [VAL_W-1:0] clip(logic signed [71:0] v);
    if (v > 72'sh7fffffff) return 32'sh7fffffff;
    if (v < -72'sh80000000) return 32'sh80000000;
    return v[VAL_W-1:0];
  endfunction

  // work out the result items of one accepted item
  task automatic predict_results(in_item_t it);
    int ra, ca, rb, cb, nr, nc, kind;
    bit a1, b1, same;
    logic [1:0] md;
    logic signed [71:0] acc;
    logic signed [VAL_W-1:0] x, y, v;
    out_item_t o;
    md = regs[REG_MODE][1:0];
    ra = eff_dim(regs[REG_ROWS_A]); ca = eff_dim(regs[REG_COLS_A]);
    rb = eff_dim(regs[REG_ROWS_B]); cb = eff_dim(regs[REG_COLS_B]);
    a1 = (ra == 1 && ca == 1); b1 = (rb == 1 && cb == 1);
    same = (ra == rb && ca == cb);
    if (it.action == ACT_WR_A) begin
      mat_a[{it.row, it.col}] = it.value;
    end else if (it.action == ACT_WR_B) begin
      mat_b[{it.row, it.col}] = it.value;
    end else if (it.action == ACT_COMPUTE) begin
      kind = -1; nr = 0; nc = 0;
      if (md == MODE_TRANS) begin
        kind = int'(KIND_TRANS); nr = ca; nc = ra;
      end else if (md == MODE_ADD) begin
        if (b1) begin kind = int'(KIND_A_B00); nr = ra; nc = ca; end
        else if (a1) begin kind = int'(KIND_A00_B); nr = rb; nc = cb; end
        else if (same) begin kind = int'(KIND_ELEM); nr = ra; nc = ca; end
      end else if (md == MODE_SUB) begin
        if (b1) begin kind = int'(KIND_A_B00); nr = ra; nc = ca; end
        else if (same) begin kind = int'(KIND_ELEM); nr = ra; nc = ca; end
      end else begin
        if (a1) begin kind = int'(KIND_A00_B); nr = rb; nc = cb; end
        else if (b1) begin kind = int'(KIND_A_B00); nr = ra; nc = ca; end
        else if (ca == rb) begin kind = int'(KIND_MATMUL); nr = ra; nc = cb; end
      end
      if (kind < 0) begin
        o = '{out_row: '0, out_col: '0, out_value: '0, last: 1'b1, error: 1'b1};
        result_q = {result_q, o};
      end else begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            if (kind == int'(KIND_TRANS)) begin
              v = mat_a[cell_idx(j, i)];
            end else if (md == MODE_MUL) begin
              acc = '0;
              if (kind == int'(KIND_MATMUL)) begin
                for (int k = 0; k < ca; k++)
                  acc += longint'(mat_a[cell_idx(i, k)]) * longint'(mat_b[cell_idx(k, j)]);
              end else if (kind == int'(KIND_A00_B)) begin
                acc = longint'(mat_b[cell_idx(i, j)]) * longint'(mat_a[cell_idx(0, 0)]);
              end else begin
                acc = longint'(mat_a[cell_idx(i, j)]) * longint'(mat_b[cell_idx(0, 0)]);
              end
              v = clip((acc + 72'sd32768) >>> 16);
            end else begin
              if (kind == int'(KIND_ELEM)) begin
                x = mat_a[cell_idx(i, j)]; y = mat_b[cell_idx(i, j)];
              end else if (kind == int'(KIND_A_B00)) begin
                x = mat_a[cell_idx(i, j)]; y = mat_b[cell_idx(0, 0)];
              end else begin
                x = mat_b[cell_idx(i, j)]; y = mat_a[cell_idx(0, 0)];
              end
              acc = (md == MODE_SUB) ? longint'(x) - longint'(y) : longint'(x) + longint'(y);
              v = clip(acc);
            end
            o.out_row = i[IDX_W-1:0];
            o.out_col = j[IDX_W-1:0];
            o.out_value = v;
            o.last = (i == nr - 1 && j == nc - 1);
            o.error = 1'b0;
            result_q = {result_q, o};
          end
        end
      end
    end
  endtask

  // drop valid and let everything drain before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic [1:0] md, logic [3:0] ra, logic [3:0] ca,
                            logic [3:0] rb, logic [3:0] cb);
    logic [CFG_DATA_W-1:0] vals [5];
    vals = '{CFG_DATA_W'(md), ra, ca, rb, cb};
    wait_idle();
    for (int r = 0; r < 5; r++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data <= vals[CFG_IDX_W'(r)];
      @(posedge clk);
      regs[CFG_IDX_W'(r)] = vals[CFG_IDX_W'(r)];
    end
    cfg_we <= 1'b0;
  endtask

  // hand one item to the block; a typed result replaces the prediction
  task automatic send_item(in_item_t it, bit typed, out_item_t exp_res);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    n_items++;
    if (it.action == ACT_COMPUTE) n_computes++;
    if (typed) result_q = {result_q, exp_res};
    else predict_results(it);
  endtask

  // result side: random stall per item, compare with oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (result_q.size() == 0) begin
          $error("unexpected result item row=%0d col=%0d value=%h",
                 out_item.out_row, out_item.out_col, out_item.out_value);
          fails++;
        end else begin
          e = result_q.pop_front();
          if (out_item.error) n_size_errs++;
          if (out_item.out_row !== e.out_row) begin
            $error("out_row: expected %0d, got %0d", e.out_row, out_item.out_row); fails++;
          end
          if (out_item.out_col !== e.out_col) begin
            $error("out_col: expected %0d, got %0d", e.out_col, out_item.out_col); fails++;
          end
          if (out_item.out_value !== e.out_value) begin
            $error("out_value: expected %h, got %h", e.out_value, out_item.out_value); fails++;
          end
          if (out_item.last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, out_item.last); fails++;
          end
          if (out_item.error !== e.error) begin
            $error("error: expected %0b, got %0b", e.error, out_item.error); fails++;
          end
        end
        out_hold = quiet ? 0 : $urandom_range(0, 7);
      end
      out_stall <= (out_hold != 0);
      if (out_hold != 0) out_hold--;
    end
  end

  typedef struct {
    logic [1:0] md;
    logic [3:0] ra, ca, rb, cb;
    in_item_t   it;
    bit         typed;
    logic signed [VAL_W-1:0] ev;
    bit         eerr;
  } stim_row_t;

  function automatic stim_row_t mk(logic [1:0] md, logic [3:0] ra, logic [3:0] ca,
                                   logic [3:0] rb, logic [3:0] cb, logic [1:0] act,
                                   int r, int c, logic [31:0] val, bit typed,
                                   logic [31:0] ev, bit eerr);
    stim_row_t s;
    s.md = md; s.ra = ra; s.ca = ca; s.rb = rb; s.cb = cb;
    s.it.action = act; s.it.row = r[IDX_W-1:0]; s.it.col = c[IDX_W-1:0];
    s.it.value = val;
    s.typed = typed; s.ev = ev; s.eerr = eerr;
    return s;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3ffff)
                                           : -$urandom_range(0, 32'h3ffff);
    endcase
  endfunction

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // one random pass: settings, a run of element loads with the odd no-op item, then a compute
  task automatic random_pass();
    logic [1:0] md;
    logic [3:0] ra, ca, rb, cb;
    in_item_t it;
    int nw, shape;
    quiet = ($urandom_range(0, 4) == 0);
    md = 2'($urandom_range(0, 3));
    ra = pick_dim(); ca = pick_dim(); rb = pick_dim(); cb = pick_dim();
    shape = $urandom_range(0, 9);
    if (md == MODE_MUL) begin
      if (shape < 6) rb = ca;
      else if (shape < 8) begin rb = 4'd1; cb = 4'd1; end
    end else begin
      if (shape < 6) begin rb = ra; cb = ca; end
      else if (shape < 8) begin rb = 4'd1; cb = 4'd1; end
      else if (shape < 9) begin ra = 4'd1; ca = 4'd1; end
    end
    write_regs(md, ra, ca, rb, cb);
    nw = $urandom_range(2, 14);
    for (int w = 0; w < nw; w++) begin
      it.action = ($urandom_range(0, 9) == 0) ? ACT_NOP : 2'($urandom_range(0, 1));
      it.row = IDX_W'($urandom_range(0, 7));
      it.col = IDX_W'($urandom_range(0, 7));
      it.value = pick_value();
      send_item(it, 1'b0, '0);
    end
    it = '0;
    it.action = ACT_COMPUTE;
    it.row = IDX_W'($urandom_range(0, 7));
    it.col = IDX_W'($urandom_range(0, 7));
    it.value = $urandom();
    send_item(it, 1'b0, '0);
  endtask

  initial begin
    stim_row_t dir [$];
    in_item_t  it;
    out_item_t er;
    bit        first;
    for (int k = 0; k < 5; k++) regs[CFG_IDX_W'(k)] = (k == 0) ? '0 : 4'd1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load every element of both stores so no compute reads an unwritten one
    for (int s = 0; s < 2; s++)
      for (int c = 0; c < CELLS; c++) begin
        it.action = s ? ACT_WR_B : ACT_WR_A;
        it.row = IDX_W'(c / MAX_DIM);
        it.col = IDX_W'(c % MAX_DIM);
        it.value = (c == 0) ? 32'd0 : $urandom();
        send_item(it, 1'b0, '0);
      end

    // directed: saturation, scalar forms, size errors, extreme dimensions
    dir = {dir, mk(MODE_ADD, 1, 1, 1, 1, ACT_WR_A, 0, 0, 32'h7fffffff, 0, 0, 0)};
    dir = {dir, mk(MODE_ADD, 1, 1, 1, 1, ACT_WR_B, 0, 0, 32'h00000001, 0, 0, 0)};
    dir = {dir, mk(MODE_ADD, 1, 1, 1, 1, ACT_COMPUTE, 0, 0, 0, 1, 32'h7fffffff, 0)};
    dir = {dir, mk(MODE_ADD, 1, 1, 1, 1, ACT_WR_A, 0, 0, 32'h80000000, 0, 0, 0)};
    dir = {dir, mk(MODE_SUB, 1, 1, 1, 1, ACT_COMPUTE, 7, 7, 32'hffffffff, 1, 32'h80000000, 0)};
    dir = {dir, mk(MODE_MUL, 1, 1, 1, 1, ACT_COMPUTE, 0, 0, 0, 0, 0, 0)};
    dir = {dir, mk(MODE_TRANS, 1, 1, 1, 1, ACT_COMPUTE, 0, 0, 0, 1, 32'h80000000, 0)};
    dir = {dir, mk(MODE_ADD, 1, 1, 1, 1, ACT_NOP, 5, 2, 32'h5a5a5a5a, 0, 0, 0)};
    dir = {dir, mk(MODE_ADD, 1, 1, 1, 1, ACT_WR_A, 7, 7, 32'h7fffffff, 0, 0, 0)};
    dir = {dir, mk(MODE_ADD, 1, 1, 1, 1, ACT_WR_B, 7, 7, 32'h7fffffff, 0, 0, 0)};
    dir = {dir, mk(MODE_ADD, 15, 8, 8, 15, ACT_COMPUTE, 0, 0, 0, 0, 0, 0)};
    dir = {dir, mk(MODE_MUL, 15, 8, 8, 15, ACT_COMPUTE, 0, 0, 0, 0, 0, 0)};
    dir = {dir, mk(MODE_TRANS, 0, 15, 3, 3, ACT_COMPUTE, 0, 0, 0, 0, 0, 0)};
    dir = {dir, mk(MODE_ADD, 2, 3, 3, 2, ACT_COMPUTE, 0, 0, 0, 1, 0, 1)};
    dir = {dir, mk(MODE_SUB, 1, 1, 2, 2, ACT_COMPUTE, 0, 0, 0, 1, 0, 1)};
    dir = {dir, mk(MODE_MUL, 2, 3, 2, 3, ACT_COMPUTE, 0, 0, 0, 1, 0, 1)};
    dir = {dir, mk(MODE_ADD, 1, 1, 3, 3, ACT_COMPUTE, 0, 0, 0, 0, 0, 0)};
    dir = {dir, mk(MODE_MUL, 1, 1, 2, 2, ACT_COMPUTE, 0, 0, 0, 0, 0, 0)};
    dir = {dir, mk(MODE_MUL, 3, 2, 1, 1, ACT_COMPUTE, 0, 0, 0, 0, 0, 0)};
    dir = {dir, mk(MODE_SUB, 2, 2, 1, 1, ACT_COMPUTE, 0, 0, 0, 0, 0, 0)};
    dir = {dir, mk(MODE_MUL, 2, 3, 3, 4, ACT_COMPUTE, 0, 0, 0, 0, 0, 0)};

    first = 1'b1;
    foreach (dir[n]) begin
      if (first || dir[n].md != regs[REG_MODE][1:0] || dir[n].ra != regs[REG_ROWS_A] ||
          dir[n].ca != regs[REG_COLS_A] || dir[n].rb != regs[REG_ROWS_B] ||
          dir[n].cb != regs[REG_COLS_B])
        write_regs(dir[n].md, dir[n].ra, dir[n].ca, dir[n].rb, dir[n].cb);
      first = 1'b0;
      er = '{out_row: '0, out_col: '0, out_value: dir[n].ev, last: 1'b1,
             error: dir[n].eerr};
      send_item(dir[n].it, dir[n].typed, er);
    end

    // random passes until enough items have gone in
    while (n_items < ITEM_GOAL) random_pass();

    wait_idle();
    repeat (2 * SETTLE) @(posedge clk);
    $display("%0d items in, %0d computes, %0d result items checked (%0d size errors)",
             n_items, n_computes, n_results, n_size_errs);
    if (fails == 0) begin
      $display("** matrix_add_sub_mul_transpose: PASSED **");
    end else begin
      $display("** matrix_add_sub_mul_transpose: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("** matrix_add_sub_mul_transpose: FAILED **");
    $finish;
  end

endmodule
